// File: rtl/wid_pkg.sv
// Package for the weighted index draw: widths, command codes and controller states.
package wid_pkg;

	localparam int MAX_WEIGHTS_DEF = 1024;
	localparam int WEIGHT_BITS     = 16;
	localparam int FIELD_BITS      = 16;
	localparam int SUM_BITS        = 26;
	localparam int INDEX_BITS      = 10;
	localparam int CMD_BITS        = 2;
	localparam int IN_TDATA_BITS   = 32;
	localparam int OUT_TDATA_BITS  = 16;

	localparam logic [FIELD_BITS-1:0] WEIGHT_MASK = (WEIGHT_BITS >= FIELD_BITS) ?
		{FIELD_BITS{1'b1}} : FIELD_BITS'((64'd1 << WEIGHT_BITS) - 64'd1);
	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

	typedef enum logic [CMD_BITS-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_DRAW  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

endpackage

// File: rtl/weighted_index_draw.sv
// Top level of the weighted index draw: cumulative weight table and binary search.
//
// Input stream s_axis carries one command per transaction: clear the table,
// load one Q0.16 weight, or draw one index against a Q0.16 random fraction.
// Loads append the saturated running sum to a cumulative table held in RAM;
// loads beyond MAX_WEIGHTS entries are dropped. A draw returns one transaction
// on m_axis with the first index whose cumulative sum exceeds the fraction,
// and a found flag in tuser (index 0, found 0 when none does).
// Clear and load complete in the accepting cycle and give no output.
// A draw is accepted, then runs its search steps, at most ceil(log2(n+1))
// steps for n stored entries (11 for 1024): each step is one RAM read whose
// data selects the next address in the same cycle. The last step writes the
// result into the output register when that register is free.
// No command is taken while a search runs. The output register lets a new
// command be taken while a result waits; a draw whose search ends while the
// previous result is still held waits in a done state until m_axis_tready.
// Reset empties the table (count and running sum to zero); RAM contents are
// left as they are, as only entries below the count are read.
module weighted_index_draw
	import wid_pkg::*;
#(
	parameter int MAX_WEIGHTS = MAX_WEIGHTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,  // weight[15:0], random_value[31:16]
	input  logic [CMD_BITS-1:0]       s_axis_tuser,  // cmd[1:0]
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,  // index[9:0], zeros[15:10]
	output logic                      m_axis_tuser   // found
);

	localparam int AW = $clog2(MAX_WEIGHTS);
	localparam int CW = $clog2(MAX_WEIGHTS + 1);
	localparam int IW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_WEIGHTS);

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [SUM_BITS-1:0] sum_q, sum_d;
	logic [CW-1:0]       lo_q, lo_d;
	logic [CW-1:0]       hi_q, hi_d;
	logic [CW-1:0]       mid_q, mid_d;
	logic [FIELD_BITS-1:0] rnd_q, rnd_d;
	logic                out_valid_q, out_valid_d;
	logic [CW-1:0]       out_pos_q, out_pos_d;
	logic                out_found_q, out_found_d;

	logic                  accept;
	cmd_t                  cmd;
	logic [FIELD_BITS-1:0] weight_m;
	logic [FIELD_BITS-1:0] rnd_in;
	logic [SUM_BITS:0]     sum_add;
	logic [SUM_BITS-1:0]   sum_sat;
	logic                  we;
	logic [AW-1:0]         raddr;
	logic [SUM_BITS-1:0]   rdata;
	logic                  gt;
	logic [CW-1:0]         nlo, nhi, nmid;
	logic                  slot_free;
	logic [IW-1:0]         pos_ext;

	assign cmd      = cmd_t'(s_axis_tuser);
	assign weight_m = s_axis_tdata[FIELD_BITS-1:0] & WEIGHT_MASK;
	assign rnd_in   = s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS];
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign sum_add  = {1'b0, sum_q} + (SUM_BITS+1)'(weight_m);
	assign sum_sat  = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];

	assign gt        = rdata > SUM_BITS'(rnd_q);
	assign nlo       = gt ? lo_q : mid_q + CW'(1);
	assign nhi       = gt ? mid_q : hi_q;
	assign nmid      = nlo + ((nhi - nlo) >> 1);
	assign slot_free = !out_valid_q || m_axis_tready;

	wid_ram #(
		.WIDTH (SUM_BITS),
		.DEPTH (MAX_WEIGHTS)
	) u_cum_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata (sum_sat),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		sum_d         = sum_q;
		lo_d          = lo_q;
		hi_d          = hi_q;
		mid_d         = mid_q;
		rnd_d         = rnd_q;
		out_valid_d   = out_valid_q && !m_axis_tready;
		out_pos_d     = out_pos_q;
		out_found_d   = out_found_q;
		s_axis_tready = 1'b0;
		we            = 1'b0;
		raddr         = nmid[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				raddr         = AW'(count_q >> 1);
				if (accept) begin
					unique case (cmd)
						CMD_CLEAR: begin
							count_d = '0;
							sum_d   = '0;
						end
						CMD_LOAD: begin
							if (count_q < MAX_COUNT) begin
								we      = 1'b1;
								sum_d   = sum_sat;
								count_d = count_q + CW'(1);
							end
						end
						CMD_DRAW: begin
							rnd_d = rnd_in;
							lo_d  = '0;
							hi_d  = count_q;
							mid_d = count_q >> 1;
							if (count_q == '0) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_SEARCH;
							end
						end
						CMD_NOP: begin
						end
						default: begin
						end
					endcase
				end
			end
			ST_SEARCH: begin
				lo_d  = nlo;
				hi_d  = nhi;
				mid_d = nmid;
				if (nlo >= nhi) begin
					if (slot_free) begin
						out_valid_d = 1'b1;
						out_pos_d   = nlo;
						out_found_d = nlo < count_q;
						state_d     = ST_IDLE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					out_pos_d   = lo_q;
					out_found_d = lo_q < count_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			sum_q       <= sum_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q        <= lo_d;
		hi_q        <= hi_d;
		mid_q       <= mid_d;
		rnd_q       <= rnd_d;
		out_pos_q   <= out_pos_d;
		out_found_q <= out_found_d;
	end

	assign pos_ext       = out_found_q ? IW'(out_pos_q) : '0;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_BITS'(pos_ext[INDEX_BITS-1:0]);
	assign m_axis_tuser  = out_found_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_COUNT)
		else $error("entry count beyond capacity");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> (lo_q < hi_q) && (hi_q <= count_q) && (mid_q < hi_q))
		else $error("search window out of range");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q != ST_IDLE))
		else $error("result raised without a draw in progress");

endmodule

// File: rtl/wid_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module wid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: verif/wid_checker.sv
// Checker for the weighted index draw: tracks the cumulative table and scores each draw result.
`timescale 1ns / 100ps

module wid_checker
	import wid_pkg::*;
#(
	parameter int MAX_WEIGHTS = MAX_WEIGHTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,  // weight[15:0], random_value[31:16]
	input  logic [CMD_BITS-1:0]       s_axis_tuser,  // cmd[1:0]
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	input  logic [OUT_TDATA_BITS-1:0] m_axis_tdata,  // index[9:0], zeros[15:10]
	input  logic                      m_axis_tuser,  // found
	output int                        fail_count,
	output int                        pending
);

	typedef struct packed {
		logic [INDEX_BITS-1:0] index;
		logic                  found;
	} draw_result_t;

	logic [SUM_BITS-1:0] cum_sums [MAX_WEIGHTS];
	int unsigned         entry_count  = 0;
	logic [SUM_BITS-1:0] weight_total = '0;
	draw_result_t        results_due[$];

	function automatic void add_weight(logic [FIELD_BITS-1:0] w);
		logic [SUM_BITS:0] s;
		if (entry_count >= MAX_WEIGHTS)
			return;
		s = {1'b0, weight_total} + (w & WEIGHT_MASK);
		if (s > SUM_MAX)
			s = {1'b0, SUM_MAX};
		weight_total = s[SUM_BITS-1:0];
		cum_sums[entry_count] = weight_total;
		entry_count++;
	endfunction

	// first entry whose cumulative sum is strictly above r
	function automatic draw_result_t search_draw(logic [FIELD_BITS-1:0] r);
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  mid;
		draw_result_t res;
		lo = 0;
		hi = entry_count;
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			if (cum_sums[mid] > r)
				hi = mid;
			else
				lo = mid + 1;
		end
		res.found = (lo < entry_count);
		res.index = res.found ? lo[INDEX_BITS-1:0] : '0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		draw_result_t want;
		if (!arst_n) begin
			entry_count  = 0;
			weight_total = '0;
			fail_count   = 0;
			results_due.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0) begin
					$error("unexpected result transaction: index %0d found %0d",
						m_axis_tdata[INDEX_BITS-1:0], m_axis_tuser);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					if (m_axis_tdata[INDEX_BITS-1:0] !== want.index) begin
						$error("index: expected %0d, actual %0d", want.index,
							m_axis_tdata[INDEX_BITS-1:0]);
						fail_count++;
					end
					if (m_axis_tuser !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tdata[OUT_TDATA_BITS-1:INDEX_BITS] !== '0) begin
						$error("pad: expected 0, actual %0h",
							m_axis_tdata[OUT_TDATA_BITS-1:INDEX_BITS]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (cmd_t'(s_axis_tuser))
					CMD_CLEAR: begin
						entry_count  = 0;
						weight_total = '0;
					end
					CMD_LOAD: add_weight(s_axis_tdata[FIELD_BITS-1:0]);
					CMD_DRAW: results_due = {results_due,
						search_draw(s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS])};
					default: ;
				endcase
			end
		end
		pending = results_due.size();
	end

endmodule

// File: verif/tb_weighted_index_draw.sv
// Testbench top for the weighted index draw: command stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_weighted_index_draw
	import wid_pkg::*;
();

	localparam int CYCLE_LIMIT = 400000;
	localparam int SMALL_ITEMS = 150;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
	logic [CMD_BITS-1:0]       s_axis_tuser = CMD_NOP;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic                      m_axis_tuser;

	int fail_count;
	int pending_results;
	int send_idle_pct = 10;
	int recv_idle_pct = 65;
	int items_sent = 0;
	int cycle_count = 0;
	int unsigned table_sums[$];

	weighted_index_draw dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	wid_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one transaction; tracks the table so draws can aim at its boundaries
	task automatic push_command(cmd_t op, logic [15:0] w, logic [15:0] r);
		int unsigned last;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {r, w};
		do @(posedge clk); while (!s_axis_tready);
		case (op)
			CMD_CLEAR: begin
				table_sums.delete();
				items_sent++;
			end
			CMD_LOAD: begin
				if (table_sums.size() < MAX_WEIGHTS_DEF) begin
					last = (table_sums.size() == 0) ? 0 : table_sums[$];
					table_sums = {table_sums, last + w};
					items_sent++;
				end
			end
			CMD_DRAW: items_sent++;
			default: ;
		endcase
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_fraction();
		int unsigned k;
		int unsigned s;
		if (table_sums.size() == 0 || $urandom_range(2) == 0)
			return 16'($urandom);
		k = $urandom_range(table_sums.size() - 1);
		s = table_sums[k] + $urandom_range(2) - 1;
		if (s > 32'hFFFF)
			return 16'($urandom);
		return s[15:0];
	endfunction

	function automatic logic [15:0] pick_weight(int style);
		case (style)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 255));
			2: begin
				case ($urandom_range(4))
					0: return 16'h0000;
					1: return 16'h0001;
					2: return 16'hFFFF;
					3: return 16'h8000;
					default: return 16'($urandom);
				endcase
			end
			default: return 16'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic push_noise();
		case ($urandom_range(2))
			0: push_command(CMD_NOP, 16'($urandom), 16'($urandom));
			1: push_command(CMD_DRAW, 16'($urandom), pick_fraction());
			default: push_command(CMD_CLEAR, 16'($urandom), 16'($urandom));
		endcase
	endtask

	task automatic run_episode();
		int n_loads;
		int n_draws;
		int style;
		if ($urandom_range(9) < 8)
			push_command(CMD_CLEAR, 16'($urandom), 16'($urandom));
		n_loads = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
		style   = $urandom_range(3);
		repeat (n_loads) begin
			push_command(CMD_LOAD, pick_weight(style), 16'($urandom));
			if ($urandom_range(19) == 0)
				push_noise();
		end
		n_draws = $urandom_range(1, 8);
		repeat (n_draws) push_command(CMD_DRAW, 16'($urandom), pick_fraction());
		if ($urandom_range(3) == 0)
			drain_results();
	endtask

	// small weights so the full table spreads over the whole fraction range
	task automatic fill_table();
		int k;
		push_command(CMD_CLEAR, '0, '0);
		for (k = 0; k < MAX_WEIGHTS_DEF; k++) begin
			push_command(CMD_LOAD, 16'($urandom_range(0, 127)), 16'($urandom));
			if (k % 128 == 127)
				push_command(CMD_DRAW, 16'($urandom), pick_fraction());
		end
		repeat (6) push_command(CMD_LOAD, 16'hFFFF, 16'($urandom));
		repeat (48) push_command(CMD_DRAW, 16'($urandom), pick_fraction());
		push_command(CMD_DRAW, '0, 16'hFFFF);
		drain_results();
	endtask

	initial begin
		int phase;
		int goal;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unused command, zero weight and exact boundaries
		push_command(CMD_DRAW, 16'h0000, 16'h0000);
		push_command(CMD_DRAW, 16'hFFFF, 16'hFFFF);
		push_command(CMD_NOP, 16'hFFFF, 16'hFFFF);
		push_command(CMD_LOAD, 16'h0000, 16'hFFFF);
		push_command(CMD_DRAW, 16'hFFFF, 16'h0000);
		push_command(CMD_LOAD, 16'hFFFF, 16'h0000);
		push_command(CMD_DRAW, 16'h0000, 16'h0000);
		push_command(CMD_DRAW, 16'h0000, 16'hFFFE);
		push_command(CMD_DRAW, 16'h0000, 16'hFFFF);
		push_command(CMD_LOAD, 16'h0001, 16'hFFFF);
		push_command(CMD_DRAW, 16'hFFFF, 16'hFFFF);
		drain_results();
		push_command(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
		push_command(CMD_DRAW, 16'h0000, 16'h0005);
		push_command(CMD_LOAD, 16'h8000, 16'h0000);
		push_command(CMD_LOAD, 16'h8000, 16'h0000);
		push_command(CMD_DRAW, 16'h0000, 16'h7FFF);
		push_command(CMD_DRAW, 16'h0000, 16'h8000);
		push_command(CMD_NOP, 16'h0000, 16'h0000);
		push_command(CMD_DRAW, 16'h0000, 16'hFFFF);
		drain_results();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 65;
				end
				1: begin
					send_idle_pct = 65;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase == 1)
				fill_table();
			goal = items_sent + SMALL_ITEMS;
			while (items_sent < goal)
				run_episode();
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: weighted_index_draw.f
rtl/wid_pkg.sv
rtl/wid_ram.sv
rtl/weighted_index_draw.sv
verif/wid_checker.sv
verif/tb_weighted_index_draw.sv
